FILE: design/lrtf_pkg.sv
// lrtf_pkg: shared types and constants of the longest-remaining-time-first scheduler
// holds field widths, the task record, the result record and the sequencer states
// no dependencies
`timescale 1ns / 1ps

package lrtf_pkg;

   localparam int ID_W        = 8;
   localparam int ARR_W       = 16;
   localparam int BURST_W     = 16;
   localparam int TIME_W      = 21;
   localparam int MAX_TASKS_D = 16;

   typedef struct packed {
      logic [ID_W-1:0]    task_id;
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [BURST_W-1:0] remain;
      logic [TIME_W-1:0]  comp;
   } rec_type;

   typedef struct packed {
      logic [ID_W-1:0]    task_id;
      logic [ARR_W-1:0]   arrival_time;
      logic [BURST_W-1:0] burst_length;
      logic               last_task;
   } load_type;

   typedef struct packed {
      logic [ID_W-1:0]   task_id_res;
      logic [TIME_W-1:0] completion_time;
      logic [TIME_W-1:0] turnaround_time;
      logic [TIME_W-1:0] waiting_time;
      logic              last_result;
   } res_type;

   typedef enum logic [2:0] {
      S_LOAD,
      S_INIT,
      S_PICK,
      S_APPLY,
      S_SORT,
      S_EMIT
   } state_type;

endpackage

FILE: design/lrtf_if.sv
// lrtf_req_if / lrtf_rsp_if: valid-ready channels of the scheduler
// depends on lrtf_pkg for field widths
`timescale 1ns / 1ps

interface lrtf_req_if;
   logic                        valid;
   logic                        ready;
   logic [lrtf_pkg::ID_W-1:0]    task_id;
   logic [lrtf_pkg::ARR_W-1:0]   arrival_time;
   logic [lrtf_pkg::BURST_W-1:0] burst_length;
   logic                        last_task;

   modport source (output valid, task_id, arrival_time, burst_length, last_task,
                   input ready);
   modport sink (input valid, task_id, arrival_time, burst_length, last_task,
                 output ready);
endinterface

interface lrtf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lrtf_pkg::ID_W-1:0]   task_id_res;
   logic [lrtf_pkg::TIME_W-1:0] completion_time;
   logic [lrtf_pkg::TIME_W-1:0] turnaround_time;
   logic [lrtf_pkg::TIME_W-1:0] waiting_time;
   logic                        last_result;

   modport source (output valid, task_id_res, completion_time, turnaround_time,
                   waiting_time, last_result, input ready);
   modport sink (input valid, task_id_res, completion_time, turnaround_time,
                 waiting_time, last_result, output ready);
endinterface

FILE: design/lrtf_mem.sv
// lrtf_mem: task table, one write port and one registered read port
// depends on lrtf_pkg for the task record
`timescale 1ns / 1ps

module lrtf_mem #(
   parameter int DEPTH = lrtf_pkg::MAX_TASKS_D,
   parameter int IW    = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IW-1:0]     wr_addr,
   input  lrtf_pkg::rec_type wr_data,
   input  logic [IW-1:0]     rd_addr,
   output lrtf_pkg::rec_type rd_data
);

   lrtf_pkg::rec_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: design/lrtf_core.sv
// lrtf_core: load sequencer, slice-by-slice table scan and arrival-ordered result scan
// depends on lrtf_pkg and drives the lrtf_mem task table
`timescale 1ns / 1ps

module lrtf_core #(
   parameter int MAX_TASKS = lrtf_pkg::MAX_TASKS_D,
   parameter int IW        = 4,
   parameter int CW        = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               ld_valid,
   output logic               ld_ready,
   input  lrtf_pkg::load_type ld_item,
   output logic               res_valid,
   input  logic               res_ready,
   output lrtf_pkg::res_type  res_item,
   output logic               wr_en,
   output logic [IW-1:0]      wr_addr,
   output lrtf_pkg::rec_type  wr_data,
   output logic [IW-1:0]      rd_addr,
   input  lrtf_pkg::rec_type  rd_data
);

   localparam int TW = lrtf_pkg::TIME_W;
   localparam int AW = lrtf_pkg::ARR_W;

   lrtf_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      loaded_ff, loaded_in;
   logic [CW-1:0]      rd_cnt_ff, rd_cnt_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [IW-1:0]      rd_idx_ff, rd_idx_in;
   logic [CW-1:0]      left_ff, left_in;
   logic [TW-1:0]      time_ff, time_in;
   logic               found_ff, found_in;
   lrtf_pkg::rec_type  best_ff, best_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   logic [AW-1:0]      min_ff, min_in;
   logic [CW-1:0]      rank_ff, rank_in;
   logic [AW-1:0]      prev_arr_ff, prev_arr_in;
   logic [IW-1:0]      prev_idx_ff, prev_idx_in;

   logic              scan_st, issue, first, scan_last, found_prev, ld_fire, room;
   logic [CW-1:0]     n_m1, left_prev;
   logic [AW-1:0]     min_prev;
   logic [TW-1:0]     time_p1;
   lrtf_pkg::rec_type upd;

   assign n_m1      = loaded_ff - CW'(1);
   assign scan_st   = (state_ff == lrtf_pkg::S_INIT) || (state_ff == lrtf_pkg::S_PICK) ||
                      (state_ff == lrtf_pkg::S_SORT);
   assign issue     = scan_st && (rd_cnt_ff < loaded_ff);
   assign first     = (rd_idx_ff == '0);
   assign scan_last = scan_st && rd_pend_ff && (rd_idx_ff == n_m1[IW-1:0]);
   assign found_prev = first ? 1'b0 : found_ff;
   assign min_prev  = first ? '1 : min_ff;
   assign left_prev = first ? '0 : left_ff;
   assign time_p1   = time_ff + TW'(1);
   assign room      = (loaded_ff < CW'(MAX_TASKS));
   assign ld_ready  = (state_ff == lrtf_pkg::S_LOAD);
   assign ld_fire   = ld_valid && ld_ready;
   assign rd_addr   = rd_cnt_ff[IW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lrtf_pkg::S_LOAD: begin
            if (ld_fire && (ld_item.last_task || !room)) begin
               state_in = lrtf_pkg::S_INIT;
            end
         end
         lrtf_pkg::S_INIT: begin
            if (scan_last) begin
               state_in = (left_in == '0) ? lrtf_pkg::S_SORT : lrtf_pkg::S_PICK;
            end
         end
         lrtf_pkg::S_PICK: begin
            if (scan_last) begin
               state_in = lrtf_pkg::S_APPLY;
            end
         end
         lrtf_pkg::S_APPLY: begin
            state_in = (left_in == '0) ? lrtf_pkg::S_SORT : lrtf_pkg::S_PICK;
         end
         lrtf_pkg::S_SORT: begin
            if (scan_last) begin
               state_in = lrtf_pkg::S_EMIT;
            end
         end
         lrtf_pkg::S_EMIT: begin
            if (res_ready) begin
               state_in = (rank_ff == n_m1) ? lrtf_pkg::S_LOAD : lrtf_pkg::S_SORT;
            end
         end
         default: state_in = lrtf_pkg::S_LOAD;
      endcase
   end

   // datapath and memory control
   always_comb begin
      loaded_in   = loaded_ff;
      rd_cnt_in   = scan_st ? (issue ? rd_cnt_ff + CW'(1) : rd_cnt_ff) : '0;
      rd_pend_in  = issue;
      rd_idx_in   = rd_cnt_ff[IW-1:0];
      left_in     = left_ff;
      time_in     = time_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      min_in      = min_ff;
      rank_in     = rank_ff;
      prev_arr_in = prev_arr_ff;
      prev_idx_in = prev_idx_ff;
      wr_en       = 1'b0;
      wr_addr     = rd_idx_ff;
      wr_data     = rd_data;
      upd         = best_ff;
      res_valid   = 1'b0;
      res_item.task_id_res     = best_ff.task_id;
      res_item.completion_time = best_ff.comp;
      res_item.turnaround_time = best_ff.comp - TW'(best_ff.arrival);
      res_item.waiting_time    = res_item.turnaround_time - TW'(best_ff.burst);
      res_item.last_result     = (rank_ff == n_m1);
      if (scan_last) begin
         rd_cnt_in = '0;
      end
      case (state_ff)
         lrtf_pkg::S_LOAD: begin
            rank_in = '0;
            if (ld_fire && room) begin
               wr_en           = 1'b1;
               wr_addr         = loaded_ff[IW-1:0];
               wr_data.task_id = ld_item.task_id;
               wr_data.arrival = ld_item.arrival_time;
               wr_data.burst   = ld_item.burst_length;
               wr_data.remain  = ld_item.burst_length;
               wr_data.comp    = '0;
               loaded_in       = loaded_ff + CW'(1);
            end
         end
         lrtf_pkg::S_INIT: begin
            if (rd_pend_ff) begin
               min_in  = (rd_data.arrival < min_prev) ? rd_data.arrival : min_prev;
               left_in = left_prev + CW'(rd_data.remain != '0);
               // a zero burst finishes on arrival
               if (rd_data.remain == '0) begin
                  wr_en        = 1'b1;
                  wr_data.comp = TW'(rd_data.arrival);
               end
               if (scan_last) begin
                  time_in = TW'(min_in);
               end
            end
         end
         lrtf_pkg::S_PICK: begin
            if (rd_pend_ff) begin
               found_in = found_prev;
               min_in   = min_prev;
               if (rd_data.remain != '0) begin
                  if (rd_data.arrival < min_prev) begin
                     min_in = rd_data.arrival;
                  end
                  if (TW'(rd_data.arrival) <= time_ff) begin
                     found_in = 1'b1;
                     if (!found_prev || (rd_data.remain > best_ff.remain) ||
                         ((rd_data.remain == best_ff.remain) &&
                          (rd_data.arrival < best_ff.arrival))) begin
                        best_in     = rd_data;
                        best_idx_in = rd_idx_ff;
                     end
                  end
               end
            end
         end
         lrtf_pkg::S_APPLY: begin
            if (found_ff) begin
               upd.remain = best_ff.remain - lrtf_pkg::BURST_W'(1);
               time_in    = time_p1;
               if (upd.remain == '0) begin
                  upd.comp = time_p1;
                  left_in  = left_ff - CW'(1);
               end
               wr_en   = 1'b1;
               wr_addr = best_idx_ff;
               wr_data = upd;
            end else begin
               // idle until the next unfinished arrival
               time_in = TW'(min_ff);
            end
         end
         lrtf_pkg::S_SORT: begin
            if (rd_pend_ff) begin
               found_in = found_prev;
               if ((rank_ff == '0) || (rd_data.arrival > prev_arr_ff) ||
                   ((rd_data.arrival == prev_arr_ff) && (rd_idx_ff > prev_idx_ff))) begin
                  found_in = 1'b1;
                  if (!found_prev || (rd_data.arrival < best_ff.arrival)) begin
                     best_in     = rd_data;
                     best_idx_in = rd_idx_ff;
                  end
               end
            end
         end
         lrtf_pkg::S_EMIT: begin
            res_valid = res_ready;
            if (res_ready) begin
               prev_arr_in = best_ff.arrival;
               prev_idx_in = best_idx_ff;
               rank_in     = rank_ff + CW'(1);
               if (rank_ff == n_m1) begin
                  loaded_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lrtf_pkg::S_LOAD;
         loaded_ff  <= '0;
         rd_cnt_ff  <= '0;
         rd_pend_ff <= 1'b0;
         time_ff    <= '0;
         rank_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         loaded_ff  <= loaded_in;
         rd_cnt_ff  <= rd_cnt_in;
         rd_pend_ff <= rd_pend_in;
         time_ff    <= time_in;
         rank_ff    <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      left_ff     <= left_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      min_ff      <= min_in;
      prev_arr_ff <= prev_arr_in;
      prev_idx_ff <= prev_idx_in;
   end

endmodule

FILE: design/longest_remaining_time_first_sched.sv
// longest_remaining_time_first_sched: preemptive longest-remaining-time-first scheduler
// depends on lrtf_pkg, lrtf_if, lrtf_mem and lrtf_core
//
// req_bus carries one task per item: id, arrival, burst and a last flag. Tasks
// are stored one a cycle. The item flagged last, or any item that arrives while
// MAX_TASKS tasks are stored (that item is dropped), starts the run.
// The run walks the task table once to find the start time, then once per time
// slice to pick the task with the most time left, or to jump to the next
// arrival when nothing is ready. Slice count equals the sum of bursts.
// Results then leave on rsp_bus in arrival order, ties in load order, one per
// task after a table scan each; last_result marks the final one.
// req_bus.ready is high only while tasks are being loaded.
// A result sits in an output register until rsp_bus.ready takes it; the block
// waits with the next result while the receiver stalls.
// reset empties the table count, zeroes the time and returns to loading;
// the table itself needs no clearing.
`timescale 1ns / 1ps

module longest_remaining_time_first_sched #(
   parameter int MAX_TASKS = lrtf_pkg::MAX_TASKS_D
) (
   input logic        clock,
   input logic        reset,
   lrtf_req_if.sink   req_bus,
   lrtf_rsp_if.source rsp_bus
);

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   lrtf_pkg::load_type ld_item;
   lrtf_pkg::res_type  res_item, rsp_ff, rsp_in;
   lrtf_pkg::rec_type  wr_data, rd_data;
   logic               res_valid, res_ready, ld_ready, wr_en;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]      wr_addr, rd_addr;

   assign ld_item.task_id      = req_bus.task_id;
   assign ld_item.arrival_time = req_bus.arrival_time;
   assign ld_item.burst_length = req_bus.burst_length;
   assign ld_item.last_task    = req_bus.last_task;
   assign req_bus.ready        = ld_ready;

   lrtf_core #(
      .MAX_TASKS (MAX_TASKS),
      .IW        (IW),
      .CW        (CW)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .ld_valid  (req_bus.valid),
      .ld_ready  (ld_ready),
      .ld_item   (ld_item),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_item  (res_item),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   lrtf_mem #(
      .DEPTH (MAX_TASKS),
      .IW    (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_item;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.task_id_res     = rsp_ff.task_id_res;
   assign rsp_bus.completion_time = rsp_ff.completion_time;
   assign rsp_bus.turnaround_time = rsp_ff.turnaround_time;
   assign rsp_bus.waiting_time    = rsp_ff.waiting_time;
   assign rsp_bus.last_result     = rsp_ff.last_result;

   a_res_room: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> res_ready)
      else $error("result produced while output register is held");

   a_reset_load: assert property (@(posedge clock)
      $past(reset) |-> req_bus.ready)
      else $error("not loading after reset");

   a_last_reload: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_item.last_result) |=> req_bus.ready)
      else $error("no return to loading after final result");

endmodule
